/* rtl/swmd_pkg.sv */
// Shared constants for the sliding-window mean and deviation block.
package swmd_pkg;

  localparam int SAMPLE_W      = 29;
  localparam int SQUARE_W      = 2 * SAMPLE_W;
  localparam int CFG_W         = 6;
  localparam int IN_TDATA_W    = 32;
  localparam int OUT_TDATA_W   = 64;
  localparam int MAX_WINDOW_DEF = 32;

  localparam logic [CFG_W-1:0]    WINDOW_RESET = CFG_W'(20);
  // the one pattern below -(2^28-1) and its saturated value
  localparam logic [SAMPLE_W-1:0] SAMPLE_OVER  = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic [SAMPLE_W-1:0] SAMPLE_FLOOR = {1'b1, {(SAMPLE_W-2){1'b0}}, 1'b1};

endpackage

/* rtl/sliding_window_mean_deviation.sv */
// Sliding-window mean and RMS deviation of signed delay samples.
// Each request runs in order: ring read, window sum, mean divide, difference, multiply,
//   square-sum update, mean-square divide, root, output register. Only one is in flight;
//   it uses the shared bit-serial divider (two passes), 29-step shift-add multiplier, root unit.
// The next request is taken once the result sits in the output register; a held result stalls.
// Reset (rst, synchronous): window length 20, windows empty, no result pending.
module sliding_window_mean_deviation #(
  parameter int MAX_WINDOW = swmd_pkg::MAX_WINDOW_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // config write: window length, taken only between requests, empties both windows
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [swmd_pkg::CFG_W-1:0]          cfg_data,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [swmd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,   // [28:0] delay_sample
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [swmd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata    // [28:0] mean_delay,
                                                              // [57:29] deviation
);

  import swmd_pkg::*;

  localparam int CW   = $clog2(MAX_WINDOW + 1);      // fill count / length
  localparam int SW   = $clog2(MAX_WINDOW);          // ring slot
  localparam int LW   = (CW > CFG_W) ? CW : CFG_W;   // length compare width
  localparam int SUMW = SAMPLE_W + $clog2(MAX_WINDOW);  // signed sample sum
  localparam int SQW  = SQUARE_W + $clog2(MAX_WINDOW);  // unsigned square sum
  localparam int DW   = SQW;                         // divider dividend
  localparam int DBW  = $clog2(DW + 1);
  localparam int RW   = (SQW + 1) / 2;
  localparam int MCW  = $clog2(SAMPLE_W + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_SUM, S_DIVM, S_DIFF, S_MUL, S_SQS, S_DIVS, S_SQRT, S_DONE
  } state_t;

  state_t state;

  // configuration and window state
  logic [CFG_W-1:0]        win_cfg;
  logic [CW-1:0]           win_len;
  logic [CW-1:0]           fill_count;
  logic [SW-1:0]           write_slot;
  logic signed [SUMW-1:0]  sample_sum;
  logic [SQW-1:0]          square_sum;

  // per-request working registers
  logic [SAMPLE_W-1:0]     x;
  logic                    full;
  logic                    sum_neg;
  logic [SAMPLE_W-1:0]     mean;
  logic [SAMPLE_W-1:0]     mag;
  logic [SQUARE_W-1:0]     prod;
  logic [MCW-1:0]          mcnt;

  // output register
  logic [SAMPLE_W-1:0]     out_mean;
  logic [SAMPLE_W-1:0]     out_dev;

  // ring memories
  logic [SAMPLE_W-1:0]     old_sample;
  logic [SQUARE_W-1:0]     old_square;
  logic                    ring_we;

  // shared divider and root unit
  logic                    div_start;
  logic [DW-1:0]           div_dividend;
  logic [CW-1:0]           div_divisor;
  logic [DBW-1:0]          div_bits;
  logic                    div_done;
  logic [DW-1:0]           div_q;
  logic                    sqrt_start;
  logic                    sqrt_done;
  logic [RW-1:0]           sqrt_root;

  // combinational helpers
  logic [LW-1:0]           cfg_ext;
  logic                    full_now;
  logic signed [SUMW-1:0]  sum_next;
  logic [SUMW-1:0]         sum_mag;
  logic [CW-1:0]           fill_next;
  logic [SQW-1:0]          sqsum_next;
  logic [CW-1:0]           slot_inc;
  logic [SW-1:0]           slot_next;
  logic signed [SAMPLE_W:0] diff;
  logic [SAMPLE_W:0]       add;
  logic [SAMPLE_W-1:0]     q_low;
  logic                    out_free;

  // effective length: zero reads as one, above MAX_WINDOW clamps
  always_comb begin
    cfg_ext = LW'(win_cfg);
    if (win_cfg == '0) begin
      win_len = CW'(1);
    end else if (cfg_ext > LW'(MAX_WINDOW)) begin
      win_len = CW'(MAX_WINDOW);
    end else begin
      win_len = CW'(cfg_ext);
    end
  end

  always_comb begin
    full_now  = (fill_count == win_len);
    fill_next = full_now ? fill_count : fill_count + CW'(1);
    sum_next  = sample_sum + SUMW'($signed(x))
              - (full_now ? SUMW'($signed(old_sample)) : SUMW'(0));
    sum_mag   = sum_next[SUMW-1] ? SUMW'(-sum_next) : SUMW'(sum_next);
    sqsum_next = square_sum + SQW'(prod) - (full ? SQW'(old_square) : SQW'(0));
    slot_inc  = CW'(write_slot) + CW'(1);
    slot_next = (slot_inc < win_len) ? slot_inc[SW-1:0] : '0;
    diff      = $signed({x[SAMPLE_W-1], x}) - $signed({mean[SAMPLE_W-1], mean});
    add       = {1'b0, prod[SQUARE_W-1:SAMPLE_W]} + (prod[0] ? {1'b0, mag} : '0);
    q_low     = div_q[SAMPLE_W-1:0];
    out_free  = !m_axis_tvalid || m_axis_tready;
  end

  // divider requests: mean magnitude first, then mean square
  always_comb begin
    div_start    = 1'b0;
    div_dividend = {sum_mag, {(DW-SUMW){1'b0}}};
    div_divisor  = fill_next;
    div_bits     = DBW'(SUMW);
    case (state)
      S_SUM: begin
        div_start = 1'b1;
      end
      S_SQS: begin
        div_start    = 1'b1;
        div_dividend = sqsum_next;
        div_divisor  = fill_count;
        div_bits     = DBW'(DW);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  assign sqrt_start    = (state == S_DIVS) && div_done;
  assign ring_we       = (state == S_SQS);
  assign cfg_ready     = (state == S_IDLE);
  assign s_axis_tready = (state == S_IDLE) && !cfg_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W - 2*SAMPLE_W){1'b0}}, out_dev, out_mean};

  swmd_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WINDOW)) u_sample_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (write_slot),
    .wdata (x),
    .raddr (write_slot),
    .rdata (old_sample)
  );

  swmd_ram #(.WIDTH(SQUARE_W), .DEPTH(MAX_WINDOW)) u_square_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (write_slot),
    .wdata (prod),
    .raddr (write_slot),
    .rdata (old_square)
  );

  swmd_div #(.DW(DW), .VW(CW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .bits     (div_bits),
    .done     (div_done),
    .quotient (div_q)
  );

  swmd_sqrt #(.IW(SQW)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (div_q),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      win_cfg       <= WINDOW_RESET;
      fill_count    <= '0;
      write_slot    <= '0;
      sample_sum    <= '0;
      square_sum    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        // new length starts fresh windows
        win_cfg    <= cfg_data;
        fill_count <= '0;
        write_slot <= '0;
        sample_sum <= '0;
        square_sum <= '0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            x     <= (s_axis_tdata[SAMPLE_W-1:0] == SAMPLE_OVER) ?
                     SAMPLE_FLOOR : s_axis_tdata[SAMPLE_W-1:0];
            state <= S_READ;
          end
        end
        S_READ: begin
          // ring read of the current slot lands this cycle
          state <= S_SUM;
        end
        S_SUM: begin
          full       <= full_now;
          fill_count <= fill_next;
          sample_sum <= sum_next;
          sum_neg    <= sum_next[SUMW-1];
          state      <= S_DIVM;
        end
        S_DIVM: begin
          if (div_done) begin
            mean  <= sum_neg ? SAMPLE_W'(-q_low) : q_low;
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          mag   <= diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
          prod  <= '0;
          mcnt  <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          // first pass loads the multiplier, then shift-add one bit a cycle
          if (mcnt == '0 && prod == '0) begin
            prod <= {{SAMPLE_W{1'b0}}, mag};
            mcnt <= MCW'(1);
          end else begin
            prod <= {add, prod[SAMPLE_W-1:1]};
            mcnt <= mcnt + MCW'(1);
            if (mcnt == MCW'(SAMPLE_W)) begin
              state <= S_SQS;
            end
          end
        end
        S_SQS: begin
          square_sum <= sqsum_next;
          write_slot <= slot_next;
          state      <= S_DIVS;
        end
        S_DIVS: begin
          if (div_done) begin
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          // root stays in the unit until its next start
          if (sqrt_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_mean      <= mean;
            out_dev       <= sqrt_root[SAMPLE_W-1:0];
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_in_window: assert property (@(posedge clk) disable iff (rst)
    fill_count <= win_len) else $error("fill count exceeds window length");

  a_slot_in_window: assert property (@(posedge clk) disable iff (rst)
    CW'(write_slot) < win_len) else $error("write slot outside window");

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken while one is in flight");

  a_result_waits: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && m_axis_tvalid && !m_axis_tready |=> state == S_DONE)
    else $error("result overwrote a pending output");
`endif

endmodule

/* rtl/swmd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module swmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/swmd_div.sv */
// Restoring divider, one quotient bit per cycle, dividend loaded left aligned.
module swmd_div #(
  parameter int DW   = 64,
  parameter int VW   = 6,
  parameter int CNTW = $clog2(DW + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [DW-1:0]   dividend,
  input  logic [VW-1:0]   divisor,
  input  logic [CNTW-1:0] bits,
  output logic            done,
  output logic [DW-1:0]   quotient
);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [VW-1:0]   rem;
  logic [VW-1:0]   dvs;
  logic [DW-1:0]   q;
  logic [VW:0]     shifted;
  logic [VW:0]     trial;
  logic            ge;

  always_comb begin
    shifted = {rem, q[DW-1]};
    trial   = shifted - {1'b0, dvs};
    ge      = shifted >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= bits;
        rem  <= '0;
        q    <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= ge ? trial[VW-1:0] : shifted[VW-1:0];
        q   <= {q[DW-2:0], ge};
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = q;

endmodule

/* rtl/swmd_sqrt.sv */
// Floor square root, one root bit (two radicand bits) per cycle.
module swmd_sqrt #(
  parameter int IW = 64,
  parameter int RW = (IW + 1) / 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [IW-1:0] radicand,
  output logic          done,
  output logic [RW-1:0] root
);

  localparam int PW   = 2 * RW;
  localparam int CNTW = $clog2(RW + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [PW-1:0]   val;
  logic [RW:0]     rem;
  logic [RW-1:0]   rt;
  logic [RW+1:0]   shifted;
  logic [RW+1:0]   trial;
  logic [RW+1:0]   diffv;
  logic            ge;

  always_comb begin
    shifted = {rem[RW-1:0], val[PW-1:PW-2]};
    trial   = {rt, 2'b01};
    diffv   = shifted - trial;
    ge      = shifted >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(RW);
        val  <= PW'(radicand);
        rem  <= '0;
        rt   <= '0;
      end else if (busy) begin
        val <= {val[PW-3:0], 2'b00};
        rem <= ge ? diffv[RW:0] : shifted[RW:0];
        rt  <= {rt[RW-2:0], ge};
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = rt;

endmodule
